// File: rtl/core/set_assoc_lru_cache_sim_assert.svh
// assertion macros for the set-associative cache model
// both expect clk and arst_n in the scope where they are used
`ifndef SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/sac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package sac_pkg;

	// fixed field widths
	localparam int ADDR_W        = 32;
	localparam int TAG_W         = 30;
	localparam int CNT_W         = 32;
	localparam int HIT_CNT_W     = 2;
	localparam int SET_BITS_W    = 4;
	localparam int OFFSET_BITS_W = 5;
	localparam int WAYS_CFG_W    = 4;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 5;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

	// access commands
	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_IFETCH = 2'd3
	} cmd_t;

endpackage

// File: rtl/core/sac_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_if
// Handshake channels of the cache model: access items, results, config.
// ----------------------------------------------------------------------------

// access item channel
interface sac_req_if;
	import sac_pkg::*;
	logic              valid;
	logic              ready;
	cmd_t              cmd;
	logic [ADDR_W-1:0] addr;
	modport source (output valid, cmd, addr, input ready);
	modport sink   (input valid, cmd, addr, output ready);
endinterface

// result item channel
interface sac_rsp_if;
	import sac_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [HIT_CNT_W-1:0] hit_count;
	logic                 miss_flag;
	logic                 evict_flag;
	logic [CNT_W-1:0]     total_hits;
	logic [CNT_W-1:0]     total_misses;
	logic [CNT_W-1:0]     total_evictions;
	modport source (output valid, hit_count, miss_flag, evict_flag, total_hits,
		total_misses, total_evictions, input ready);
	modport sink (input valid, hit_count, miss_flag, evict_flag, total_hits,
		total_misses, total_evictions, output ready);
endinterface

// configuration write channel
interface sac_cfg_if;
	import sac_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/sac_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_queue
// Two-entry FIFO between the classifying front and the lookup back end.
// ----------------------------------------------------------------------------
module sac_queue #(
	parameter int WIDTH = 39
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	logic [DEPTH-1:0][WIDTH-1:0] buf_q;
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [PTR_W:0]              count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = buf_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) buf_q[wr_ptr_q] <= wdata;
	end

endmodule

// File: rtl/core/sac_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_front
// Takes access items, drops instruction fetches and splits the address
// into set index and tag by the configured bit counts.
// ----------------------------------------------------------------------------
module sac_front #(
	parameter int MAX_SET_BITS = 8,
	parameter int ADDR_BITS    = 32
) (
	sac_req_if.sink                             req,
	input  logic [sac_pkg::SET_BITS_W-1:0]      set_bits,
	input  logic [sac_pkg::OFFSET_BITS_W-1:0]   offset_bits,
	input  logic                                hold,
	input  logic                                q_full,
	output logic                                push,
	output logic [MAX_SET_BITS-1:0]             set_idx,
	output logic [sac_pkg::TAG_W-1:0]           tag,
	output logic                                modify
);
	import sac_pkg::*;

	localparam int EXT_W = (ADDR_BITS > TAG_W) ? ADDR_BITS : TAG_W;
	localparam int SH_W  = ((SET_BITS_W > OFFSET_BITS_W) ? SET_BITS_W : OFFSET_BITS_W) + 1;

	logic [SET_BITS_W-1:0]   sbits;
	logic [EXT_W-1:0]        addr_ext;
	logic [EXT_W-1:0]        set_sh;
	logic [EXT_W-1:0]        tag_sh;
	logic [MAX_SET_BITS-1:0] set_mask;
	logic [SH_W-1:0]         tag_amt;

	// handshake: no items while the queue is full or during the clearing pass
	assign req.ready = !q_full && !hold;
	assign push      = req.valid && req.ready && (req.cmd != CMD_IFETCH);
	assign modify    = (req.cmd == CMD_MODIFY);

	// set index bits saturate at the largest supported count
	assign sbits = (int'(set_bits) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits;

	// address split
	assign addr_ext = EXT_W'(req.addr[ADDR_BITS-1:0]);
	assign set_sh   = addr_ext >> offset_bits;
	assign set_mask = ~({MAX_SET_BITS{1'b1}} << sbits);
	assign set_idx  = set_sh[MAX_SET_BITS-1:0] & set_mask;
	assign tag_amt  = SH_W'(sbits) + SH_W'(offset_bits);
	assign tag_sh   = addr_ext >> tag_amt;
	assign tag      = tag_sh[TAG_W-1:0];

endmodule

// File: rtl/core/sac_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_back
// Set memory, tag lookup, LRU update, running totals and result register.
// ----------------------------------------------------------------------------
module sac_back #(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sac_pkg::WAYS_CFG_W-1:0]      ways_cfg,
	input  logic                                q_empty,
	output logic                                q_pop,
	input  logic [MAX_SET_BITS-1:0]             q_set,
	input  logic [sac_pkg::TAG_W-1:0]           q_tag,
	input  logic                                q_modify,
	output logic                                clearing,
	sac_rsp_if.source                           rsp
);
	import sac_pkg::*;

	localparam int NSETS = 1 << MAX_SET_BITS;
	localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam logic [RW:0] RANK_MAX  = (RW+1)'(MAX_WAYS - 1);
	localparam logic [RW:0] RANK_FILL = (RW+1)'(MAX_WAYS);

	typedef struct packed {
		logic [MAX_WAYS-1:0]         valid;
		logic [MAX_WAYS-1:0][RW-1:0] rank;
	} meta_t;

	typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t                  state_q;
	logic [MAX_SET_BITS-1:0] clr_idx_q;
	logic                    rsp_valid_q;
	logic [HIT_CNT_W-1:0]    hit_count_q;
	logic                    miss_q;
	logic                    evict_q;
	logic [CNT_W-1:0]        hit_total_q;
	logic [CNT_W-1:0]        miss_total_q;
	logic [CNT_W-1:0]        evict_total_q;

	meta_t    meta_mem [NSETS];
	tag_row_t tag_mem  [NSETS];
	meta_t    meta_rd_q;
	tag_row_t tag_rd_q;

	logic [MAX_SET_BITS-1:0] set_q;
	logic [TAG_W-1:0]        tag_q;
	logic                    modify_q;

	logic                    slot_free;
	logic                    meta_we;
	logic [MAX_SET_BITS-1:0] meta_waddr;
	meta_t                   meta_wdata;

	logic [MAX_WAYS-1:0]     in_use;
	logic [MAX_WAYS-1:0]     hit_vec;
	logic [MAX_WAYS-1:0]     inv_vec;
	logic                    hit_any;
	logic                    inv_any;
	logic [RW-1:0]           hit_way;
	logic [RW-1:0]           inv_way;
	logic [RW-1:0]           vic_way;
	logic [RW-1:0]           best_rank;
	logic [RW-1:0]           chosen;
	logic [RW:0]             ref_rank;
	meta_t                   meta_new;
	tag_row_t                tag_new;
	logic                    miss;
	logic                    evict;
	logic [HIT_CNT_W-1:0]    hit_add;
	logic [CNT_W:0]          hit_sum;
	logic [CNT_W:0]          miss_sum;
	logic [CNT_W:0]          evict_sum;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty && slot_free;
	assign clearing  = (state_q == ST_CLEAR);

	// way lookup, victim choice and recency update for the fetched set
	always_comb begin
		hit_way   = '0;
		inv_way   = '0;
		vic_way   = '0;
		best_rank = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w]  = (w == 0) || (int'(ways_cfg) > w);
			hit_vec[w] = in_use[w] && meta_rd_q.valid[w] && (tag_rd_q[w] == tag_q);
			inv_vec[w] = in_use[w] && !meta_rd_q.valid[w];
		end
		hit_any = |hit_vec;
		inv_any = |inv_vec;
		// lowest matching way wins
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) hit_way = RW'(w);
			if (inv_vec[w]) inv_way = RW'(w);
		end
		// oldest way, lowest index on ties
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (in_use[w] && (meta_rd_q.rank[w] > best_rank)) begin
				best_rank = meta_rd_q.rank[w];
				vic_way   = RW'(w);
			end
		end
		miss  = !hit_any;
		evict = !hit_any && !inv_any;
		if (hit_any) begin
			chosen   = hit_way;
			ref_rank = {1'b0, meta_rd_q.rank[hit_way]};
		end else if (inv_any) begin
			chosen   = inv_way;
			ref_rank = RANK_FILL;
		end else begin
			chosen   = vic_way;
			ref_rank = {1'b0, best_rank};
		end
		meta_new = meta_rd_q;
		tag_new  = tag_rd_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (in_use[w]) begin
				if (RW'(w) == chosen) begin
					meta_new.valid[w] = 1'b1;
					meta_new.rank[w]  = '0;
					tag_new[w]        = tag_q;
				end else if (meta_rd_q.valid[w] && ({1'b0, meta_rd_q.rank[w]} < ref_rank)
						&& ({1'b0, meta_rd_q.rank[w]} < RANK_MAX)) begin
					meta_new.rank[w] = meta_rd_q.rank[w] + 1'b1;
				end
			end
		end
		// a modify's second access always hits the line just touched
		hit_add   = HIT_CNT_W'(hit_any) + HIT_CNT_W'(modify_q);
		hit_sum   = {1'b0, hit_total_q} + (CNT_W+1)'(hit_add);
		miss_sum  = {1'b0, miss_total_q} + (CNT_W+1)'(miss);
		evict_sum = {1'b0, evict_total_q} + (CNT_W+1)'(evict);
	end

	// metadata write port: clearing pass or write-back of the looked-up set
	always_comb begin
		meta_we    = (state_q == ST_CLEAR) || (state_q == ST_LOOKUP);
		meta_waddr = (state_q == ST_CLEAR) ? clr_idx_q : set_q;
		meta_wdata = (state_q == ST_CLEAR) ? meta_t'('0) : meta_new;
	end

	// valid and recency memory
	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
		if (q_pop) meta_rd_q <= meta_mem[q_set];
	end

	// tag memory, never cleared
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) tag_mem[set_q] <= tag_new;
		if (q_pop) tag_rd_q <= tag_mem[q_set];
	end

	// item in flight
	always_ff @(posedge clk) begin
		if (q_pop) begin
			set_q    <= q_set;
			tag_q    <= q_tag;
			modify_q <= q_modify;
		end
	end

	// sequencer, totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_idx_q     <= '0;
			rsp_valid_q   <= 1'b0;
			hit_count_q   <= '0;
			miss_q        <= 1'b0;
			evict_q       <= 1'b0;
			hit_total_q   <= '0;
			miss_total_q  <= '0;
			evict_total_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_pop) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					rsp_valid_q   <= 1'b1;
					hit_count_q   <= hit_add;
					miss_q        <= miss;
					evict_q       <= evict;
					hit_total_q   <= hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
					miss_total_q  <= miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
					evict_total_q <= evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
					state_q       <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.hit_count       = hit_count_q;
	assign rsp.miss_flag       = miss_q;
	assign rsp.evict_flag      = evict_q;
	assign rsp.total_hits      = hit_total_q;
	assign rsp.total_misses    = miss_total_q;
	assign rsp.total_evictions = evict_total_q;

endmodule

// File: rtl/core/set_assoc_lru_cache_sim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Tag-only set-associative cache model with LRU replacement and totals.
// ----------------------------------------------------------------------------
// In the back end a load, store or modify item has its set's row read from
// the set memory, then the ways are looked up, the line picked, the others
// aged and the row written back; the next item is taken only then and while
// the result register is free. The front queue holds two items; instruction
// fetches are taken and give no result. After reset a clearing pass over all
// 2**MAX_SET_BITS sets (256 by default) resets the valid and recency bits,
// during which req.ready is low; configuration writes are taken at any time.
module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_BITS    = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	sac_req_if.sink   req,
	sac_rsp_if.source rsp,
	sac_cfg_if.sink   cfg
);
	import sac_pkg::*;

	localparam int ENTRY_W = MAX_SET_BITS + TAG_W + 1;

	logic [SET_BITS_W-1:0]    set_bits_q;
	logic [OFFSET_BITS_W-1:0] offset_bits_q;
	logic [WAYS_CFG_W-1:0]    ways_q;

	logic                    f_push;
	logic [MAX_SET_BITS-1:0] f_set;
	logic [TAG_W-1:0]        f_tag;
	logic                    f_modify;
	logic                    q_full;
	logic                    q_empty;
	logic                    q_pop;
	logic [ENTRY_W-1:0]      q_rdata;
	logic                    clearing;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= SET_BITS_W'(1);
			offset_bits_q <= OFFSET_BITS_W'(1);
			ways_q        <= WAYS_CFG_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SET_BITS:    set_bits_q    <= cfg.data[SET_BITS_W-1:0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg.data[OFFSET_BITS_W-1:0];
				CFG_WAYS:        ways_q        <= cfg.data[WAYS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// classify and split incoming items
	sac_front #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.ADDR_BITS    (ADDR_BITS)
	) u_front (
		.req         (req),
		.set_bits    (set_bits_q),
		.offset_bits (offset_bits_q),
		.hold        (clearing),
		.q_full      (q_full),
		.push        (f_push),
		.set_idx     (f_set),
		.tag         (f_tag),
		.modify      (f_modify)
	);

	// decoupling queue
	sac_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_set, f_tag, f_modify}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// lookup and replacement
	sac_back #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ways_cfg (ways_q),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_set    (q_rdata[ENTRY_W-1 -: MAX_SET_BITS]),
		.q_tag    (q_rdata[TAG_W:1]),
		.q_modify (q_rdata[0]),
		.clearing (clearing),
		.rsp      (rsp)
	);

endmodule

// File: rtl/core/sac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_port_checker
// Port-level checks on the result channel of the cache model.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_sim_assert.svh"

module sac_port_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rsp_valid,
	input  logic                             rsp_ready,
	input  logic [sac_pkg::HIT_CNT_W-1:0]    hit_count,
	input  logic                             miss_flag,
	input  logic                             evict_flag,
	input  logic [sac_pkg::CNT_W-1:0]        total_hits,
	input  logic [sac_pkg::CNT_W-1:0]        total_misses
);
	import sac_pkg::*;

	// a stalled result stays valid and keeps its hit count and hit and miss totals
	`SAC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(total_hits) && $stable(total_misses) && $stable(hit_count), "stalled result changed")

	// running hit and miss totals never go down
	`SAC_ASSERT_NEXT(a_tot_mono, rsp_valid && rsp_ready, total_hits >= $past(total_hits) && total_misses >= $past(total_misses), "running total decreased")

	// every item either hits or misses
	`SAC_ASSERT_NOW(a_hit_or_miss, rsp_valid, miss_flag || (hit_count != '0), "item with neither hit nor miss")

	// an eviction comes only with a miss, and then at most the modify hit
	`SAC_ASSERT_NOW(a_evict_miss, rsp_valid && evict_flag, miss_flag && (hit_count != HIT_CNT_W'(2)), "eviction without a miss")

endmodule

bind set_assoc_lru_cache_sim sac_port_checker u_sac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.hit_count    (rsp.hit_count),
	.miss_flag    (rsp.miss_flag),
	.evict_flag   (rsp.evict_flag),
	.total_hits   (rsp.total_hits),
	.total_misses (rsp.total_misses)
);

// File: tb/sac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_checker
// Watches the access, result and config channels of the cache model. It keeps
// its own copy of the tag store, recency ranks and totals, predicts the
// outcome of every accepted access item and compares each returned result
// item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sac_checker (
	input  logic clk,
	input  logic arst_n,
	sac_req_if   req,
	sac_rsp_if   rsp,
	sac_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import sac_pkg::*;

	localparam int MAX_SET_BITS = 8;
	localparam int MAX_WAYS     = 8;
	localparam int RANK_TOP     = MAX_WAYS - 1;
	localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;

	// predicted outcome of one access item
	typedef struct packed {
		logic [HIT_CNT_W-1:0] hits;
		logic                 miss;
		logic                 evict;
		logic [CNT_W-1:0]     hit_sum;
		logic [CNT_W-1:0]     miss_sum;
		logic [CNT_W-1:0]     evict_sum;
	} access_outcome_t;

	// mirrored geometry registers
	logic [SET_BITS_W-1:0]    set_bits_q;
	logic [OFFSET_BITS_W-1:0] off_bits_q;
	logic [WAYS_CFG_W-1:0]    ways_q;

	// mirrored tag store and running totals
	bit               line_vld  [NUM_LINES];
	logic [TAG_W-1:0] line_tg   [NUM_LINES];
	logic [2:0]       line_rank [NUM_LINES];
	logic [CNT_W-1:0] hits_run;
	logic [CNT_W-1:0] misses_run;
	logic [CNT_W-1:0] evicts_run;

	access_outcome_t pending_outcomes[$];
	int err_cnt = 0;
	int queued  = 0;

	assign fail_count = err_cnt;
	assign pending    = queued;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// one tag lookup with fill or LRU eviction, updating ranks and totals
	function automatic void lookup_set(input logic [ADDR_W-1:0] addr, output bit hit,
		output bit miss, output bit evict);
		int sbits, ways, boff, base, chosen, ref_rank, best, w, i;
		logic [63:0] wide, shifted;
		logic [TAG_W-1:0] tag;
		bit found;
		sbits = (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_q);
		ways  = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : int'(ways_q));
		boff  = off_bits_q;
		wide  = {32'b0, addr};
		base  = int'((wide >> boff) & ((64'd1 << sbits) - 64'd1)) * MAX_WAYS;
		shifted = wide >> (sbits + boff);
		tag   = shifted[TAG_W-1:0];
		hit = 0;
		miss = 0;
		evict = 0;
		found = 0;
		chosen = 0;
		ref_rank = RANK_TOP + 1;

		// look up the ways in use
		for (w = 0; w < ways && !found; w++) begin
			if (line_vld[base + w] && line_tg[base + w] == tag) begin
				chosen = w;
				ref_rank = line_rank[base + w];
				found = 1;
				hit = 1;
			end
		end

		// miss: lowest invalid way, else oldest way (lowest on ties)
		if (!found) begin
			miss = 1;
			for (w = 0; w < ways && !found; w++) begin
				if (!line_vld[base + w]) begin
					chosen = w;
					found = 1;
				end
			end
			if (!found) begin
				evict = 1;
				best = 0;
				chosen = 0;
				for (w = 0; w < ways; w++) begin
					if (line_rank[base + w] > best) begin
						best = line_rank[base + w];
						chosen = w;
					end
				end
				ref_rank = line_rank[base + chosen];
			end
		end

		// age the younger lines, saturating
		for (w = 0; w < ways; w++) begin
			i = base + w;
			if (w != chosen && line_vld[i] && line_rank[i] < ref_rank && line_rank[i] < RANK_TOP)
				line_rank[i] = line_rank[i] + 3'd1;
		end
		line_vld[base + chosen]  = 1'b1;
		line_tg[base + chosen]   = tag;
		line_rank[base + chosen] = 3'd0;

		if (hit)
			hits_run = sat_inc(hits_run);
		if (miss)
			misses_run = sat_inc(misses_run);
		if (evict)
			evicts_run = sat_inc(evicts_run);
	endfunction

	function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
		input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	// track config, compare results, predict accepted items
	always @(posedge clk or negedge arst_n) begin
		access_outcome_t exp_o, got_o;
		bit h, m, e;
		if (!arst_n) begin
			set_bits_q = 4'd1;
			off_bits_q = 5'd1;
			ways_q     = 4'd1;
			for (int k = 0; k < NUM_LINES; k++) begin
				line_vld[k]  = 1'b0;
				line_tg[k]   = '0;
				line_rank[k] = 3'd0;
			end
			hits_run   = '0;
			misses_run = '0;
			evicts_run = '0;
			pending_outcomes.delete();
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_SET_BITS:    set_bits_q = cfg.data[SET_BITS_W-1:0];
					CFG_OFFSET_BITS: off_bits_q = cfg.data[OFFSET_BITS_W-1:0];
					CFG_WAYS:        ways_q     = cfg.data[WAYS_CFG_W-1:0];
					default: ;
				endcase
			end

			// returned result item
			if (rsp.valid && rsp.ready) begin
				if (pending_outcomes.size() == 0) begin
					$error("result item with no access outstanding");
					err_cnt++;
				end else begin
					exp_o = pending_outcomes.pop_front();
					got_o = '{rsp.hit_count, rsp.miss_flag, rsp.evict_flag,
						rsp.total_hits, rsp.total_misses, rsp.total_evictions};
					check_field("hit_count", exp_o.hits, got_o.hits);
					check_field("miss_flag", exp_o.miss, got_o.miss);
					check_field("evict_flag", exp_o.evict, got_o.evict);
					check_field("total_hits", exp_o.hit_sum, got_o.hit_sum);
					check_field("total_misses", exp_o.miss_sum, got_o.miss_sum);
					check_field("total_evictions", exp_o.evict_sum, got_o.evict_sum);
				end
			end

			// accepted access item, fetches give nothing
			if (req.valid && req.ready && req.cmd != CMD_IFETCH) begin
				lookup_set(req.addr, h, m, e);
				exp_o = '0;
				exp_o.hits  = h;
				exp_o.miss  = m;
				exp_o.evict = e;
				if (req.cmd == CMD_MODIFY) begin
					lookup_set(req.addr, h, m, e);
					exp_o.hits  = exp_o.hits + h;
					exp_o.miss  = exp_o.miss | m;
					exp_o.evict = exp_o.evict | e;
				end
				exp_o.hit_sum   = hits_run;
				exp_o.miss_sum  = misses_run;
				exp_o.evict_sum = evicts_run;
				pending_outcomes.push_back(exp_o);
			end
		end
		queued = pending_outcomes.size();
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the set-associative LRU cache model. A directed
// pass covers aliasing tags, saturated geometry and LRU eviction, then random
// phases switch geometry and idling mix while the checker predicts results.
// ----------------------------------------------------------------------------
module tb_top;
	import sac_pkg::*;

	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int POOL_N          = 24;
	localparam int DRAIN_CYCLES    = 12;
	localparam int HOLD_CYCLES     = 400;
	localparam int STALL_LIMIT     = 5000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;

	// idling mix and geometry currently in force
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit long_hold    = 1'b0;
	int cur_sbits    = 1;
	int cur_boff     = 1;
	int cur_ways     = 1;
	logic [ADDR_W-1:0] addr_pool [POOL_N];

	// set bits, offset bits, ways per random phase
	int geom_tab [NUM_PHASES][3] = '{
		'{1, 1, 1}, '{2, 4, 2}, '{8, 16, 8}, '{3, 5, 4}, '{0, 0, 2}, '{15, 3, 15},
		'{1, 0, 8}, '{5, 31, 6}, '{2, 2, 8}, '{6, 1, 5}, '{4, 6, 0}, '{8, 12, 8}
	};

	sac_req_if req();
	sac_rsp_if rsp();
	sac_cfg_if cfg();

	set_assoc_lru_cache_sim dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	sac_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result receiver with random stalls and one long hold-off
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold && !hold_seen) begin
				hold_seen = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no item moving on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// offer one access item, keeping valid high across back-to-back items
	task automatic issue(input cmd_t op, input logic [ADDR_W-1:0] a);
		// each cycle before the offer is idle with the sender's idle chance
		while ($urandom_range(99) < snd_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd   <= op;
		req.addr  <= a;
		do @(posedge clk); while (req.ready !== 1'b1);
	endtask

	// stop offering and wait for every outstanding result, then let fetches settle
	task automatic drain();
		req.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all three geometry registers back to back
	task automatic set_geometry(input int sb, input int ob, input int wy);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] vals [3];
		idx  = '{CFG_SET_BITS, CFG_OFFSET_BITS, CFG_WAYS};
		vals = '{CFG_DATA_W'(sb), CFG_DATA_W'(ob), CFG_DATA_W'(wy)};
		for (int k = 0; k < 3; k++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[k];
			cfg.data  <= vals[k];
			do @(posedge clk); while (cfg.ready !== 1'b1);
		end
		cfg.valid <= 1'b0;
		cur_sbits = (sb > 8) ? 8 : sb;
		cur_boff  = ob;
		cur_ways  = (wy == 0) ? 1 : ((wy > 8) ? 8 : wy);
	endtask

	// mostly addresses that revisit a few sets and tags, some noise
	function automatic logic [ADDR_W-1:0] pick_addr();
		int r;
		logic [63:0] composed;
		r = $urandom_range(99);
		if (r < 15)
			return $urandom;
		if (r < 45)
			return addr_pool[$urandom_range(POOL_N - 1)];
		composed = (64'($urandom_range(cur_ways + 2)) << (cur_sbits + cur_boff))
			| (64'($urandom_range(3)) << cur_boff)
			| (64'($urandom) & ((64'd1 << cur_boff) - 64'd1));
		return composed[ADDR_W-1:0];
	endfunction

	// stimulus
	initial begin
		int served;
		cmd_t op;
		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.cmd   = CMD_LOAD;
		req.addr  = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_SET_BITS;
		cfg.data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry: fill, hit within block, conflict eviction, modify, fetch
		issue(CMD_LOAD, 32'h0000_0000);
		issue(CMD_LOAD, 32'h0000_0000);
		issue(CMD_LOAD, 32'h0000_0001);
		issue(CMD_LOAD, 32'h0000_0002);
		issue(CMD_STORE, 32'h0000_0004);
		issue(CMD_MODIFY, 32'h0000_0000);
		issue(CMD_MODIFY, 32'h0000_0000);
		issue(CMD_IFETCH, 32'hFFFF_FFFF);
		issue(CMD_LOAD, 32'hFFFF_FFFF);
		drain();

		// no offset or index bits: top tag bits alias
		set_geometry(0, 0, 2);
		issue(CMD_LOAD, 32'h0000_0000);
		issue(CMD_LOAD, 32'hC000_0000);
		issue(CMD_LOAD, 32'h1234_5678);
		issue(CMD_LOAD, 32'hFFFF_FFFF);
		drain();

		// oversized set bits and offset, zero ways
		set_geometry(15, 31, 0);
		issue(CMD_LOAD, 32'h0000_0000);
		issue(CMD_LOAD, 32'h7FFF_FFFF);
		issue(CMD_MODIFY, 32'h8000_0001);
		drain();

		// all ways of one set, then one more tag evicts the oldest
		set_geometry(8, 16, 15);
		for (int t = 1; t <= 9; t++)
			issue(CMD_LOAD, ADDR_W'(t) << 24);
		issue(CMD_LOAD, 32'h0100_0000);
		drain();

		// random phases
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 4) begin
				snd_idle_pct = 7;
				rcv_idle_pct = 56;
			end else if (p < 8) begin
				snd_idle_pct = 56;
				rcv_idle_pct = 7;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			set_geometry(geom_tab[p][0], geom_tab[p][1], geom_tab[p][2]);
			for (int k = 0; k < POOL_N; k++)
				addr_pool[k] = $urandom;
			// receiver stops for a long stretch so the block backs up
			if (p == 2)
				long_hold = 1'b1;
			served = 0;
			while (served < ITEMS_PER_PHASE) begin
				op = ($urandom_range(99) < 15) ? CMD_IFETCH : cmd_t'($urandom_range(2));
				issue(op, pick_addr());
				served++;
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/sac_pkg.sv
rtl/core/sac_if.sv
rtl/core/sac_queue.sv
rtl/core/sac_front.sv
rtl/core/sac_back.sv
rtl/core/set_assoc_lru_cache_sim.sv
rtl/core/sac_checker.sv
tb/sac_checker.sv
tb/tb_top.sv
